// File: src/pic_pkg.sv
// Shared types, codes and constants of the priority interrupt controller.
// Used by pic_step and priority_interrupt_controller_core; no dependencies.

package pic_pkg;

	localparam int NUM_SRC     = 15;	// internal sources, pending bits 0..14
	localparam int NUM_PEND    = 17;	// internal sources plus NMI and INT
	localparam int NUM_LEVELS  = 8;
	localparam int NUM_GROUPS  = 6;	// five programmable groups plus time base
	localparam int PRIO_GROUPS = 5;
	localparam int BIT_NMI     = 15;
	localparam int BIT_INT     = 16;
	localparam int PIN_FIRST   = 5;	// pending bit of INTP0
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 3;

	localparam logic [2:0] TB_LEVEL = 3'd7;
	localparam logic [NUM_PEND-1:0] UNMASK_RST = 17'h18000;
	localparam logic [2:0] PRIO_RST = 3'd7;

	// function codes
	localparam logic [2:0] FUNC_SET_LINE = 3'd0;
	localparam logic [2:0] FUNC_POST     = 3'd1;
	localparam logic [2:0] FUNC_DISPATCH = 3'd2;
	localparam logic [2:0] FUNC_END_SVC  = 3'd3;
	localparam logic [2:0] FUNC_HALT     = 3'd4;

	// line selectors
	localparam logic [2:0] LINE_INT   = 3'd0;
	localparam logic [2:0] LINE_NMI   = 3'd1;
	localparam logic [2:0] LINE_INTP0 = 3'd2;
	localparam logic [2:0] LINE_INTP1 = 3'd3;
	localparam logic [2:0] LINE_INTP2 = 3'd4;
	localparam logic [2:0] LINE_POLL  = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UNMASK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BANK      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_TMR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_DMA  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_PIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_SER0 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PRIO_SER1 = 3'd6;

	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_NMI      = 2'd1,
		KIND_INTERNAL = 2'd2,
		KIND_INT      = 2'd3
	} kind_t;

	// source bits of each group: timer, dma, pins, serial 0, serial 1, time base
	localparam logic [NUM_SRC-1:0] GRP_MASK [NUM_GROUPS] = '{
		15'h0007, 15'h0018, 15'h00E0, 15'h0700, 15'h3800, 15'h4000
	};

	typedef struct packed {
		logic [NUM_PEND-1:0]               unmask;
		logic [NUM_SRC-1:0]                bank;
		logic [PRIO_GROUPS-1:0][2:0]       prio;
	} cfg_t;

	typedef struct packed {
		logic [NUM_PEND-1:0]   pending;
		logic [NUM_LEVELS-1:0] in_service;
		logic                  nmi_line;
		logic [2:0]            pin_lines;
		logic                  int_line;
		logic                  poll_line;
		logic                  halted;
	} state_t;

	typedef struct packed {
		logic [2:0]         func;
		logic [2:0]         line_sel;
		logic               line_level;
		logic [NUM_SRC-1:0] event_bits;
		logic               irq_enable;
		logic               inhibit;
		logic [2:0]         service_level;
	} item_t;

	typedef struct packed {
		logic                taken;
		kind_t               kind;
		logic [3:0]          source_index;
		logic [2:0]          level;
		logic                use_bank_switch;
		logic                awake;
		logic [NUM_PEND-1:0] pending_now;
	} result_t;

endpackage

// File: src/pic_step.sv
// Next-state and result logic for one item of the interrupt controller.
// Depends on pic_pkg for the state, configuration, item and result types.

module pic_step (
	input  pic_pkg::state_t  st,
	input  pic_pkg::cfg_t    cfg,
	input  pic_pkg::item_t   it,
	output pic_pkg::state_t  st_next,
	output pic_pkg::result_t res
);

	pic_pkg::state_t st_a;
	logic [1:0] pin_k;
	logic [pic_pkg::NUM_PEND-1:0] avail;
	logic [2:0] grp_lvl [pic_pkg::NUM_GROUPS];
	logic [pic_pkg::NUM_GROUPS-1:0] grp_hit;
	logic [pic_pkg::NUM_GROUPS-1:0] grp_free;
	logic [pic_pkg::NUM_LEVELS-1:0] hit_lvl;
	logic halted_w;
	logic [2:0] best_lv;
	logic [2:0] best_g;
	logic [3:0] src;
	logic serve_ok;
	logic go;

	// true when no level at or above priority lv is in service
	function automatic logic lv_free(input logic [pic_pkg::NUM_LEVELS-1:0] isv,
					 input logic [2:0] lv);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < pic_pkg::NUM_LEVELS; i++) begin
			if (i <= int'(lv) && isv[i])
				ok = 1'b0;
		end
		return ok;
	endfunction

	assign pin_k = 2'(it.line_sel - pic_pkg::LINE_INTP0);

	// line, event, end-of-service and halt updates
	always_comb begin
		st_a = st;
		unique case (it.func)
			pic_pkg::FUNC_SET_LINE: begin
				unique case (it.line_sel)
					pic_pkg::LINE_INT: begin
						st_a.int_line = it.line_level;
						st_a.pending[pic_pkg::BIT_INT] = it.line_level;
						if (it.line_level)
							st_a.halted = 1'b0;
					end
					pic_pkg::LINE_NMI: begin
						if (st.nmi_line != it.line_level) begin
							st_a.nmi_line = it.line_level;
							if (it.line_level) begin
								st_a.pending[pic_pkg::BIT_NMI] = 1'b1;
								st_a.halted = 1'b0;
							end
						end
					end
					pic_pkg::LINE_INTP0, pic_pkg::LINE_INTP1, pic_pkg::LINE_INTP2: begin
						if (st.pin_lines[pin_k] != it.line_level) begin
							st_a.pin_lines[pin_k] = it.line_level;
							if (it.line_level)
								st_a.pending[5'(pic_pkg::PIN_FIRST) + 5'(pin_k)] = 1'b1;
						end
					end
					pic_pkg::LINE_POLL: st_a.poll_line = it.line_level;
					default: ;
				endcase
			end
			pic_pkg::FUNC_POST:
				st_a.pending[pic_pkg::NUM_SRC-1:0] =
					st.pending[pic_pkg::NUM_SRC-1:0] | it.event_bits;
			pic_pkg::FUNC_END_SVC: st_a.in_service[it.service_level] = 1'b0;
			pic_pkg::FUNC_HALT: st_a.halted = 1'b1;
			default: ;
		endcase
	end

	assign avail = st_a.pending & cfg.unmask;

	always_comb begin
		for (int g = 0; g < pic_pkg::PRIO_GROUPS; g++)
			grp_lvl[g] = cfg.prio[g];
		grp_lvl[pic_pkg::NUM_GROUPS-1] = pic_pkg::TB_LEVEL;
		for (int g = 0; g < pic_pkg::NUM_GROUPS; g++) begin
			grp_hit[g] = |(avail[pic_pkg::NUM_SRC-1:0] & pic_pkg::GRP_MASK[g]);
			grp_free[g] = lv_free(st_a.in_service, grp_lvl[g]);
		end
	end

	// a halted controller wakes on any source above the first in-service level
	assign halted_w = st_a.halted && !(|(grp_hit & grp_free));

	always_comb begin
		hit_lvl = '0;
		for (int g = 0; g < pic_pkg::NUM_GROUPS; g++) begin
			if (grp_hit[g])
				hit_lvl[grp_lvl[g]] = 1'b1;
		end
		best_lv = '0;
		for (int lv = pic_pkg::NUM_LEVELS - 1; lv >= 0; lv--) begin
			if (hit_lvl[lv])
				best_lv = 3'(lv);
		end
		best_g = '0;
		for (int g = pic_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_hit[g] && grp_lvl[g] == best_lv)
				best_g = 3'(g);
		end
		src = '0;
		for (int b = pic_pkg::NUM_SRC - 1; b >= 0; b--) begin
			if (avail[b] && pic_pkg::GRP_MASK[best_g][b])
				src = 4'(b);
		end
	end

	assign serve_ok = lv_free(st_a.in_service, best_lv);

	// raw pending NMI lets dispatch through without the enable flag
	assign go = (it.func == pic_pkg::FUNC_DISPATCH) && !halted_w && !it.inhibit &&
		    (|avail) && (st_a.pending[pic_pkg::BIT_NMI] || it.irq_enable);

	always_comb begin
		st_next = st_a;
		st_next.halted = halted_w;
		res = '0;
		res.kind = pic_pkg::KIND_NONE;
		if (go) begin
			if (avail[pic_pkg::BIT_NMI]) begin
				st_next.pending[pic_pkg::BIT_NMI] = 1'b0;
				res.taken = 1'b1;
				res.kind = pic_pkg::KIND_NMI;
			end else if (|avail[pic_pkg::NUM_SRC-1:0]) begin
				// a blocked internal source also keeps INT from being served
				if (serve_ok) begin
					st_next.in_service[best_lv] = 1'b1;
					st_next.pending[{1'b0, src}] = 1'b0;
					res.taken = 1'b1;
					res.kind = pic_pkg::KIND_INTERNAL;
					res.source_index = src;
					res.level = best_lv;
					res.use_bank_switch = cfg.bank[src];
				end
			end else if (avail[pic_pkg::BIT_INT]) begin
				st_next.pending[pic_pkg::BIT_INT] = 1'b0;
				st_next.int_line = 1'b0;
				res.taken = 1'b1;
				res.kind = pic_pkg::KIND_INT;
			end
		end
		res.awake = !st_next.halted;
		res.pending_now = st_next.pending;
	end

endmodule

// File: src/priority_interrupt_controller_core.sv
// Top level of the eight-level priority interrupt controller.
// Depends on pic_pkg and pic_step.

// Sustains one item per clock: an accepted item is held in an input register and its
// whole step (line edges, event posting, end of service, halt, wake check, priority
// encode) is worked out combinationally into the result register, together with the
// controller state. Items follow straight behind one another; only a stalled result
// side holds up the input. Configuration writes take effect at the clock edge of the
// write and must be made while no item is in flight.

module priority_interrupt_controller_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// item channel
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [2:0]                        func,
	input  logic [2:0]                        line_sel,
	input  logic                              line_level,
	input  logic [pic_pkg::NUM_SRC-1:0]       event_bits,
	input  logic                              irq_enable,
	input  logic                              inhibit,
	input  logic [2:0]                        service_level,
	// result channel
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic                              taken,
	output logic [1:0]                        kind,
	output logic [3:0]                        source_index,
	output logic [2:0]                        level,
	output logic                              use_bank_switch,
	output logic                              awake,
	output logic [pic_pkg::NUM_PEND-1:0]      pending_now,
	// configuration
	input  logic                              cfg_we,
	input  logic [pic_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pic_pkg::CFG_W-1:0]         cfg_wdata
);

	pic_pkg::cfg_t    cfg_q;
	pic_pkg::state_t  state_q;
	pic_pkg::state_t  state_d;
	pic_pkg::item_t   item_s1;
	logic             valid_s1;
	pic_pkg::result_t res_d;
	pic_pkg::result_t result_q;
	logic             result_valid_q;
	logic             advance;

	assign advance = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unmask <= pic_pkg::UNMASK_RST;
			cfg_q.bank <= '0;
			for (int g = 0; g < pic_pkg::PRIO_GROUPS; g++)
				cfg_q.prio[g] <= pic_pkg::PRIO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pic_pkg::REG_UNMASK:    cfg_q.unmask <= cfg_wdata;
				pic_pkg::REG_BANK:      cfg_q.bank <= cfg_wdata[pic_pkg::NUM_SRC-1:0];
				pic_pkg::REG_PRIO_TMR:  cfg_q.prio[0] <= cfg_wdata[2:0];
				pic_pkg::REG_PRIO_DMA:  cfg_q.prio[1] <= cfg_wdata[2:0];
				pic_pkg::REG_PRIO_PIN:  cfg_q.prio[2] <= cfg_wdata[2:0];
				pic_pkg::REG_PRIO_SER0: cfg_q.prio[3] <= cfg_wdata[2:0];
				pic_pkg::REG_PRIO_SER1: cfg_q.prio[4] <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1.func <= func;
			item_s1.line_sel <= line_sel;
			item_s1.line_level <= line_level;
			item_s1.event_bits <= event_bits;
			item_s1.irq_enable <= irq_enable;
			item_s1.inhibit <= inhibit;
			item_s1.service_level <= service_level;
		end
	end

	pic_step u_step (
		.st      (state_q),
		.cfg     (cfg_q),
		.it      (item_s1),
		.st_next (state_d),
		.res     (res_d)
	);

	// state and result move together on each transfer out of the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{pending: '0, in_service: '0, nmi_line: 1'b0, pin_lines: '0,
				     int_line: 1'b0, poll_line: 1'b1, halted: 1'b0};
			result_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_d;
			if (advance)
				result_valid_q <= 1'b1;
			else if (result_ready)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res_d;
	end

	assign result_valid = result_valid_q;
	assign taken = result_q.taken;
	assign kind = result_q.kind;
	assign source_index = result_q.source_index;
	assign level = result_q.level;
	assign use_bank_switch = result_q.use_bank_switch;
	assign awake = result_q.awake;
	assign pending_now = result_q.pending_now;

	a_taken_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.taken == (result_q.kind != pic_pkg::KIND_NONE)))
		else $error("taken flag disagrees with kind");

	a_result_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> (result_q.awake == !state_q.halted &&
				    result_q.pending_now == state_q.pending))
		else $error("result out of step with controller state");

	a_level_in_service: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.kind == pic_pkg::KIND_INTERNAL)
		|=> state_q.in_service[$past(res_d.level)])
		else $error("served level not marked in service");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled item");

endmodule

// File: verif/tb_top.sv
// Self-checking testbench of priority_interrupt_controller_core: directed and random items,
// every result compared against an in-bench prediction of the controller state.
// Depends on pic_pkg and the controller RTL only.

module tb_top;

	localparam logic [2:0] FUNC_NOP_LO   = 3'd5;
	localparam logic [2:0] FUNC_NOP_HI   = 3'd7;
	localparam logic [2:0] LINE_SPARE_LO = 3'd6;
	localparam logic [2:0] LINE_SPARE_HI = 3'd7;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          item_valid = 1'b0;
	logic                          item_ready;
	logic [2:0]                    func = '0;
	logic [2:0]                    line_sel = '0;
	logic                          line_level = 1'b0;
	logic [pic_pkg::NUM_SRC-1:0]   event_bits = '0;
	logic                          irq_enable = 1'b0;
	logic                          inhibit = 1'b0;
	logic [2:0]                    service_level = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic                          taken;
	logic [1:0]                    kind;
	logic [3:0]                    source_index;
	logic [2:0]                    level;
	logic                          use_bank_switch;
	logic                          awake;
	logic [pic_pkg::NUM_PEND-1:0]  pending_now;
	logic                          cfg_we = 1'b0;
	logic [pic_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pic_pkg::CFG_W-1:0]     cfg_wdata = '0;

	priority_interrupt_controller_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.func(func), .line_sel(line_sel), .line_level(line_level),
		.event_bits(event_bits), .irq_enable(irq_enable), .inhibit(inhibit),
		.service_level(service_level),
		.result_valid(result_valid), .result_ready(result_ready),
		.taken(taken), .kind(kind), .source_index(source_index), .level(level),
		.use_bank_switch(use_bank_switch), .awake(awake), .pending_now(pending_now),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// controller copy: configuration
	logic [pic_pkg::NUM_PEND-1:0] unmask_cfg = pic_pkg::UNMASK_RST;
	logic [pic_pkg::NUM_SRC-1:0]  bank_cfg = '0;
	logic [2:0]                   prio_cfg [pic_pkg::PRIO_GROUPS] = '{pic_pkg::PRIO_RST,
		pic_pkg::PRIO_RST, pic_pkg::PRIO_RST, pic_pkg::PRIO_RST, pic_pkg::PRIO_RST};

	// controller copy: state
	logic [pic_pkg::NUM_PEND-1:0]   pend_bits = '0;
	logic [pic_pkg::NUM_LEVELS-1:0] in_svc_bits = '0;
	logic                           nmi_lvl = 1'b0;
	logic [2:0]                     pin_lvl = '0;
	logic                           int_lvl = 1'b0;
	logic                           poll_lvl = 1'b1;
	logic                           halted = 1'b0;

	pic_pkg::item_t   queued_ops [$];
	pic_pkg::result_t due_results [$];
	pic_pkg::item_t   offered_op;

	int send_idle_pct = 25;
	int recv_idle_pct = 25;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	function automatic logic [2:0] group_level(int g);
		return (g < pic_pkg::PRIO_GROUPS) ? prio_cfg[g] : pic_pkg::TB_LEVEL;
	endfunction

	// one controller step on the local copy; returns the result it should give
	task automatic serve_step(input pic_pkg::item_t it, output pic_pkg::result_t r);
		logic [pic_pkg::NUM_PEND-1:0] avail;
		logic                         stop;
		logic                         done;
		int                           lv, g, s, k;
		r = '0;
		case (it.func)
			pic_pkg::FUNC_SET_LINE: begin
				case (it.line_sel)
					pic_pkg::LINE_INT: begin
						int_lvl = it.line_level;
						pend_bits[pic_pkg::BIT_INT] = it.line_level;
						if (it.line_level)
							halted = 1'b0;
					end
					pic_pkg::LINE_NMI: begin
						if (nmi_lvl != it.line_level) begin
							nmi_lvl = it.line_level;
							if (it.line_level) begin
								pend_bits[pic_pkg::BIT_NMI] = 1'b1;
								halted = 1'b0;
							end
						end
					end
					pic_pkg::LINE_INTP0, pic_pkg::LINE_INTP1, pic_pkg::LINE_INTP2: begin
						k = int'(it.line_sel - pic_pkg::LINE_INTP0);
						if (pin_lvl[k] != it.line_level) begin
							pin_lvl[k] = it.line_level;
							if (it.line_level)
								pend_bits[pic_pkg::PIN_FIRST + k] = 1'b1;
						end
					end
					pic_pkg::LINE_POLL: poll_lvl = it.line_level;
					default: ;
				endcase
			end
			pic_pkg::FUNC_POST:
				pend_bits[pic_pkg::NUM_SRC-1:0] =
					pend_bits[pic_pkg::NUM_SRC-1:0] | it.event_bits;
			pic_pkg::FUNC_END_SVC: in_svc_bits[it.service_level] = 1'b0;
			pic_pkg::FUNC_HALT:    halted = 1'b1;
			default: ;
		endcase

		// wake when an unmasked source sits above the first level in service
		avail = pend_bits & unmask_cfg;
		stop = 1'b0;
		if (halted && avail != '0) begin
			for (lv = 0; lv < pic_pkg::NUM_LEVELS; lv++) begin
				if (!stop && in_svc_bits[lv])
					stop = 1'b1;
				for (g = 0; g < pic_pkg::NUM_GROUPS; g++)
					if (!stop && int'(group_level(g)) == lv &&
					    (avail[pic_pkg::NUM_SRC-1:0] & pic_pkg::GRP_MASK[g]) != '0)
						halted = 1'b0;
			end
		end

		if (it.func == pic_pkg::FUNC_DISPATCH && !halted && !it.inhibit && avail != '0 &&
				(pend_bits[pic_pkg::BIT_NMI] || it.irq_enable)) begin
			if (avail[pic_pkg::BIT_NMI]) begin
				pend_bits[pic_pkg::BIT_NMI] = 1'b0;
				r.taken = 1'b1;
				r.kind = pic_pkg::KIND_NMI;
			end else if (avail[pic_pkg::NUM_SRC-1:0] != '0) begin
				// a level already in service blocks everything below it, INT included
				done = 1'b0;
				stop = 1'b0;
				for (lv = 0; lv < pic_pkg::NUM_LEVELS; lv++) begin
					if (!stop && !done && in_svc_bits[lv])
						stop = 1'b1;
					for (g = 0; g < pic_pkg::NUM_GROUPS; g++) begin
						if (!stop && !done && int'(group_level(g)) == lv) begin
							for (s = 0; s < pic_pkg::NUM_SRC; s++) begin
								if (!done && pic_pkg::GRP_MASK[g][s] && avail[s]) begin
									r.source_index = 4'(s);
									r.level = 3'(lv);
									r.use_bank_switch = bank_cfg[s];
									r.taken = 1'b1;
									r.kind = pic_pkg::KIND_INTERNAL;
									in_svc_bits[lv] = 1'b1;
									pend_bits[s] = 1'b0;
									done = 1'b1;
								end
							end
						end
					end
				end
			end else if (avail[pic_pkg::BIT_INT]) begin
				pend_bits[pic_pkg::BIT_INT] = 1'b0;
				int_lvl = 1'b0;
				r.taken = 1'b1;
				r.kind = pic_pkg::KIND_INT;
			end
		end
		r.awake = !halted;
		r.pending_now = pend_bits;
	endtask

	// driver
	always @(posedge clk) begin : drive
		pic_pkg::result_t want;
		pic_pkg::item_t   nxt;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				serve_step(offered_op, want);
				due_results.push_back(want);
			end
			if (!item_valid || item_ready) begin
				if (queued_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = queued_ops.pop_front();
					offered_op = nxt;
					item_valid <= 1'b1;
					func <= nxt.func;
					line_sel <= nxt.line_sel;
					line_level <= nxt.line_level;
					event_bits <= nxt.event_bits;
					irq_enable <= nxt.irq_enable;
					inhibit <= nxt.inhibit;
					service_level <= nxt.service_level;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result-side flow control
	always @(posedge clk) begin : watch
		pic_pkg::result_t got;
		pic_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got.taken = taken;
				got.kind = pic_pkg::kind_t'(kind);
				got.source_index = source_index;
				got.level = level;
				got.use_bank_switch = use_bank_switch;
				got.awake = awake;
				got.pending_now = pending_now;
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result transfer with nothing due: pend=%05h", got.pending_now);
				end else begin
					want = due_results.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch exp t=%0d k=%0d s=%0d l=%0d b=%0d a=%0d p=%05h",
								want.taken, want.kind, want.source_index, want.level,
								want.use_bank_switch, want.awake, want.pending_now);
							$display("         got t=%0d k=%0d s=%0d l=%0d b=%0d a=%0d p=%05h",
								got.taken, got.kind, got.source_index, got.level,
								got.use_bank_switch, got.awake, got.pending_now);
						end
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic pic_pkg::item_t mk(logic [2:0] f, logic [2:0] sel, logic lvl,
			logic [pic_pkg::NUM_SRC-1:0] ev, logic ie, logic inh, logic [2:0] svc);
		pic_pkg::item_t it;
		it.func = f;
		it.line_sel = sel;
		it.line_level = lvl;
		it.event_bits = ev;
		it.irq_enable = ie;
		it.inhibit = inh;
		it.service_level = svc;
		return it;
	endfunction

	function automatic pic_pkg::item_t rand_op();
		pic_pkg::item_t it;
		int             pick;
		it = mk(3'($urandom_range(7)), 3'($urandom_range(5)), 1'($urandom_range(1)),
			15'($urandom_range(15'h7FFF)), $urandom_range(99) < 85,
			$urandom_range(99) < 12, 3'($urandom_range(7)));
		pick = $urandom_range(99);
		if (pick < 3) begin
			it.func = 3'($urandom_range(FUNC_NOP_HI, FUNC_NOP_LO));
		end else if (pick < 28) begin
			it.func = pic_pkg::FUNC_SET_LINE;
			if ($urandom_range(19) == 0)
				it.line_sel = 3'($urandom_range(LINE_SPARE_HI, LINE_SPARE_LO));
		end else if (pick < 48) begin
			it.func = pic_pkg::FUNC_POST;
			pick = $urandom_range(9);
			if (pick < 5)
				it.event_bits = 15'(1) << $urandom_range(pic_pkg::NUM_SRC - 1);
			else if (pick < 7)
				it.event_bits = (15'(1) << $urandom_range(pic_pkg::NUM_SRC - 1)) |
					(15'(1) << $urandom_range(pic_pkg::NUM_SRC - 1));
		end else if (pick < 80) begin
			it.func = pic_pkg::FUNC_DISPATCH;
		end else if (pick < 95) begin
			it.func = pic_pkg::FUNC_END_SVC;
		end else begin
			it.func = pic_pkg::FUNC_HALT;
		end
		return it;
	endfunction

	task automatic write_reg(input logic [pic_pkg::CFG_IDX_W-1:0] idx,
			input logic [pic_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			pic_pkg::REG_UNMASK:    unmask_cfg = val[pic_pkg::NUM_PEND-1:0];
			pic_pkg::REG_BANK:      bank_cfg = val[pic_pkg::NUM_SRC-1:0];
			pic_pkg::REG_PRIO_TMR:  prio_cfg[0] = val[2:0];
			pic_pkg::REG_PRIO_DMA:  prio_cfg[1] = val[2:0];
			pic_pkg::REG_PRIO_PIN:  prio_cfg[2] = val[2:0];
			pic_pkg::REG_PRIO_SER0: prio_cfg[3] = val[2:0];
			pic_pkg::REG_PRIO_SER1: prio_cfg[4] = val[2:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [pic_pkg::NUM_PEND-1:0] um,
			input logic [pic_pkg::NUM_SRC-1:0] bk,
			input logic [2:0] p_tmr, p_dma, p_pin, p_ser0, p_ser1);
		write_reg(pic_pkg::REG_UNMASK, pic_pkg::CFG_W'(um));
		write_reg(pic_pkg::REG_BANK, pic_pkg::CFG_W'(bk));
		write_reg(pic_pkg::REG_PRIO_TMR, pic_pkg::CFG_W'(p_tmr));
		write_reg(pic_pkg::REG_PRIO_DMA, pic_pkg::CFG_W'(p_dma));
		write_reg(pic_pkg::REG_PRIO_PIN, pic_pkg::CFG_W'(p_pin));
		write_reg(pic_pkg::REG_PRIO_SER0, pic_pkg::CFG_W'(p_ser0));
		write_reg(pic_pkg::REG_PRIO_SER1, pic_pkg::CFG_W'(p_ser1));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs_random();
		set_regs(17'($urandom_range(17'h1FFFF)), 15'($urandom_range(15'h7FFF)),
			3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
			3'($urandom_range(7)), 3'($urandom_range(7)));
	endtask

	// waits until every queued item has been sent and every transfer has been answered
	task automatic wait_idle();
		@(negedge clk);
		while (queued_ops.size() != 0 || item_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic queue_random(input int n, input int idle_pct);
		send_idle_pct = idle_pct;
		recv_idle_pct = idle_pct;
		repeat (n) queued_ops.push_back(rand_op());
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part: timer 3, dma 0, pins 5, serial 0 at 1, serial 1 at 7
		set_regs(17'h1FFFF, 15'h2AAA, 3'd3, 3'd0, 3'd5, 3'd1, 3'd7);
		queued_ops.push_back(mk(FUNC_NOP_HI, LINE_SPARE_HI, 1'b1, 15'h7FFF, 1'b1, 1'b1, 3'd7));
		queued_ops.push_back(mk(FUNC_NOP_LO, pic_pkg::LINE_INT, 1'b1, '0, 1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_HALT, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b1, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_INTP1, 1'b1, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_HALT, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, LINE_SPARE_LO, 1'b1, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, LINE_SPARE_HI, 1'b1, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_POLL, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_INT, 1'b1, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_NMI, 1'b1, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_NMI, 1'b1, '0,
			1'b0, 1'b0, 3'd0));
		// raw nmi lets the dispatch through with interrupts disabled
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_POST, pic_pkg::LINE_INT, 1'b0, 15'h7FFF,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b1, 1'b1, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b1, 1'b0, 3'd0));
		// level 0 now in service: nothing below it and no INT
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b1, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_HALT, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b1, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_END_SVC, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_DISPATCH, pic_pkg::LINE_INT, 1'b0, '0,
			1'b1, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_END_SVC, pic_pkg::LINE_INT, 1'b0, '0,
			1'b0, 1'b0, 3'd7));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_NMI, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		queued_ops.push_back(mk(pic_pkg::FUNC_SET_LINE, pic_pkg::LINE_INTP1, 1'b0, '0,
			1'b0, 1'b0, 3'd0));
		wait_idle();

		set_regs_random();
		queue_random(250, 25);
		wait_idle();

		// every programmable group at level 0, everything unmasked, no idling on either side
		set_regs(17'h1FFFF, 15'h7FFF, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		queue_random(250, 0);
		wait_idle();

		// only nmi and INT unmasked: the INT path gets served
		set_regs(pic_pkg::UNMASK_RST, '0, pic_pkg::PRIO_RST, pic_pkg::PRIO_RST,
			pic_pkg::PRIO_RST, pic_pkg::PRIO_RST, pic_pkg::PRIO_RST);
		queue_random(100, 25);
		wait_idle();

		set_regs('0, '0, 3'd7, 3'd0, 3'd7, 3'd0, 3'd7);
		queue_random(75, 25);
		wait_idle();

		// long result stall while the sender keeps offering
		set_regs_random();
		queue_random(250, 25);
		@(negedge clk);
		hold_req = 1'b1;
		wait_idle();

		set_regs_random();
		queue_random(200, 25);
		wait_idle();

		repeat (5) @(posedge clk);
		if (fail_count == 0 && due_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
